[hw/rtl/next_hop_router_core_defines.svh]
// Assertion macros for the next-hop router.
// Used by next_hop_router_core; needs aclk and aresetn in the including scope.
`ifndef NEXT_HOP_ROUTER_CORE_DEFINES_SVH
`define NEXT_HOP_ROUTER_CORE_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define NHR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("next_hop_router_core: check failed");

// Next-cycle implication, off while in reset.
`define NHR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next_hop_router_core: check failed");

`endif

[hw/rtl/nhr_pkg.sv]
// Shared constants and types for the next-hop router.
// No dependencies.
`default_nettype none
package nhr_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_NODE_ID    = 3'd0;
    localparam logic [2:0] REG_TOPO_MODE  = 3'd1;
    localparam logic [2:0] REG_NB_COUNT   = 3'd2;
    localparam logic [2:0] REG_NB_A       = 3'd3;
    localparam logic [2:0] REG_NB_B       = 3'd4;
    localparam logic [2:0] REG_NB_C       = 3'd5;
    localparam logic [2:0] REG_NB_D       = 3'd6;

    // result actions
    localparam logic [1:0] ACT_FORWARD = 2'd0;
    localparam logic [1:0] ACT_RUN     = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;

    localparam logic       TOPO_HCUBE  = 1'b0;
    localparam logic       TOPO_TORUS  = 1'b1;

    localparam int         NB_REGS     = 4;
    localparam logic [4:0] HOP_SCHED   = 5'h1F;   // -1, the scheduler

    // neighbor entry: vld low means the register holds a negative id
    typedef struct packed {
        logic       vld;
        logic [3:0] id;
    } nhr_nb_t;

endpackage
`default_nettype wire

[hw/rtl/next_hop_router_core.sv]
// Pipeline: 2 register stages (input, result); the result stage loads from the input stage when the output is free.
// Throughput: one word per cycle while m_tready is not held low; ready is backpressured through both stages.
// The hop decision is a 4-entry compare against the configured neighbor list.
// Reset (aresetn low, synchronous): pipeline emptied, node_id 0, hypercube rules,
// one neighbor listed, all neighbor ids -1.
// Depends on nhr_pkg and next_hop_router_core_defines.svh.
`default_nettype none
`include "next_hop_router_core_defines.svh"

module next_hop_router_core
    import nhr_pkg::*;
#(
    parameter int MAX_NEIGHBORS = 4,
    parameter int ROW_WIDTH     = 4,
    parameter int NODE_COUNT    = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_addr,
    input  wire logic [4:0] cfg_wdata,

    input  wire logic       s_tvalid,
    output      logic       s_tready,
    input  wire logic [7:0] s_tdata,    // [4:0] destination, [5] finish_flag, [7:6] zero
    input  wire logic       s_tuser,    // [0] func

    output      logic       m_tvalid,
    input  wire logic       m_tready,
    output      logic [7:0] m_tdata     // [1:0] action, [6:2] next_hop, [7] zero
);

    localparam logic [3:0] MaxNb     = 4'((MAX_NEIGHBORS < NB_REGS) ? MAX_NEIGHBORS : NB_REGS);
    localparam logic [6:0] NodeCnt   = 7'(NODE_COUNT);
    localparam logic [2:0] LastCol   = 3'(ROW_WIDTH - 1);

    // configuration
    logic [3:0] node_id_reg;
    logic       topo_reg;
    logic [2:0] nb_count_reg;
    logic [4:0] nb_reg [NB_REGS];

    // pipeline
    logic       in_vld_reg;
    logic       func_reg;
    logic [4:0] dst_reg;
    logic       fin_reg;
    logic       out_vld_reg;
    logic [1:0] act_reg;
    logic [4:0] hop_reg;

    logic       out_ready;
    logic       in_ready;
    logic [1:0] act_next;
    logic [4:0] hop_next;

    // column of each 4-bit id, worked out at elaboration
    logic [2:0] col_lut [16];

    for (genvar g = 0; g < 16; g++) begin : g_col
        assign col_lut[g] = 3'(g % ROW_WIDTH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg  <= 4'd0;
            topo_reg     <= TOPO_HCUBE;
            nb_count_reg <= 3'd1;
            for (int i = 0; i < NB_REGS; i++) begin
                nb_reg[i] <= HOP_SCHED;
            end
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_NODE_ID:   node_id_reg  <= cfg_wdata[3:0];
                REG_TOPO_MODE: topo_reg     <= cfg_wdata[0];
                REG_NB_COUNT:  nb_count_reg <= cfg_wdata[2:0];
                REG_NB_A:      nb_reg[0]    <= cfg_wdata;
                REG_NB_B:      nb_reg[1]    <= cfg_wdata;
                REG_NB_C:      nb_reg[2]    <= cfg_wdata;
                REG_NB_D:      nb_reg[3]    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_ready = !out_vld_reg || m_tready;
    assign in_ready  = !in_vld_reg || out_ready;
    assign s_tready  = in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_vld_reg <= s_tvalid;
            end
            if (out_ready) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_tvalid) begin
            func_reg <= s_tuser;
            dst_reg  <= s_tdata[4:0];
            fin_reg  <= s_tdata[5];
        end
        if (out_ready && in_vld_reg) begin
            act_reg <= act_next;
            hop_reg <= hop_next;
        end
    end

    // hop decision
    always_comb begin
        nhr_nb_t    nb [NB_REGS];
        logic [3:0] listed;
        logic       any_bad;
        logic       any_ok;
        logic [3:0] min_id;
        logic [4:0] lowest;
        logic       dst_vld;
        logic [3:0] dst_id;
        logic       exact;
        logic       col_hit;
        logic [3:0] col_id;
        logic       less_hit;
        logic [3:0] less_id;
        logic       up_hit;
        logic [3:0] up_id;
        logic [4:0] right_hop;

        dst_vld  = !dst_reg[4];
        dst_id   = dst_reg[3:0];
        any_bad  = 1'b0;
        any_ok   = 1'b0;
        min_id   = 4'd0;
        exact    = 1'b0;
        col_hit  = 1'b0;
        col_id   = 4'd0;
        less_hit = 1'b0;
        less_id  = 4'd0;
        up_hit   = 1'b0;
        up_id    = 4'd0;

        for (int i = 0; i < NB_REGS; i++) begin
            nb[i].vld = !nb_reg[i][4];
            nb[i].id  = nb_reg[i][3:0];
            listed[i] = (4'(i) < {1'b0, nb_count_reg}) && (4'(i) < MaxNb);
            if (listed[i]) begin
                if (!nb[i].vld) begin
                    any_bad = 1'b1;
                end else begin
                    if (!any_ok || nb[i].id < min_id) begin
                        min_id = nb[i].id;
                    end
                    any_ok = 1'b1;
                    if (nb[i].id == dst_id) begin
                        exact = 1'b1;
                    end
                    if (col_lut[nb[i].id] == col_lut[dst_id]) begin
                        col_hit = 1'b1;
                        col_id  = nb[i].id;
                    end
                    if (nb[i].id < dst_id) begin
                        less_hit = 1'b1;
                        less_id  = nb[i].id;
                    end
                    if (col_lut[nb[i].id] == 3'd0 && nb[i].id < node_id_reg) begin
                        up_hit = 1'b1;
                        up_id  = nb[i].id;
                    end
                end
            end
        end

        lowest = (any_bad || !any_ok) ? HOP_SCHED : {1'b0, min_id};

        // right-hand neighbor, wrapping to the row start
        if (col_lut[node_id_reg] == LastCol || 7'(node_id_reg) + 7'd1 >= NodeCnt) begin
            right_hop = 5'({1'b0, node_id_reg} - {2'b0, col_lut[node_id_reg]});
        end else begin
            right_hop = {1'b0, node_id_reg} + 5'd1;
        end

        act_next = ACT_FORWARD;
        hop_next = 5'd0;
        if (func_reg) begin
            hop_next = lowest;
        end else if (dst_vld && dst_id == node_id_reg) begin
            act_next = fin_reg ? ACT_STOP : ACT_RUN;
        end else if (dst_vld) begin
            if (exact) begin
                hop_next = {1'b0, dst_id};
            end else if (topo_reg == TOPO_TORUS) begin
                hop_next = col_hit ? {1'b0, col_id} : right_hop;
            end else begin
                hop_next = less_hit ? {1'b0, less_id} : 5'd0;
            end
        end else begin
            if (topo_reg == TOPO_TORUS) begin
                // a listed -1 matches the scheduler destination exactly
                if (any_bad || node_id_reg == 4'd0) begin
                    hop_next = HOP_SCHED;
                end else if (up_hit) begin
                    hop_next = {1'b0, up_id};
                end else begin
                    hop_next = {1'b0, node_id_reg} - 5'd1;
                end
            end else begin
                hop_next = lowest;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, hop_reg, act_reg};

    `NHR_ASSERT_NOW(a_act_code, m_tvalid,
        act_reg == ACT_FORWARD || act_reg == ACT_RUN || act_reg == ACT_STOP)
    `NHR_ASSERT_NOW(a_local_hop_zero, m_tvalid && act_reg != ACT_FORWARD, hop_reg == 5'd0)
    `NHR_ASSERT_NEXT(a_in_hold, in_vld_reg && !out_ready,
        in_vld_reg && $stable(dst_reg) && $stable(func_reg) && $stable(fin_reg))
    `NHR_ASSERT_NOW(a_out_source, $rose(out_vld_reg), $past(in_vld_reg))

endmodule
`default_nettype wire
